// ===== rtl/core/spbi_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spbi_pkg
// Shared constants, register codes and types of the symbol pair bit
// interleaver.
// ----------------------------------------------------------------------------
package spbi_pkg;

	localparam int DATA_WIDTH        = 8;
	localparam int FRAME_W           = 13;
	localparam int BPS_W             = 4;
	localparam int FILL_W            = 4;
	localparam int CFG_IDX_W         = 2;
	localparam int CFG_DATA_W        = 13;
	localparam int MAX_FRAME_SYMBOLS = 4096;
	localparam int BUF_DEPTH         = 12;
	localparam int BUF_IDX_W         = $clog2(BUF_DEPTH);
	localparam int QUEUE_DEPTH       = 2;

	localparam logic [CFG_IDX_W-1:0] REG_BITS_PER_SYMBOL = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_SYMBOLS   = CFG_IDX_W'(1);

	localparam logic [BPS_W-1:0]   BPS_RESET   = BPS_W'(2);
	localparam logic [FRAME_W-1:0] FRAME_RESET = FRAME_W'(2);

	typedef struct packed {
		logic [DATA_WIDTH-1:0] data;
		logic [BUF_IDX_W-1:0]  widx;
		logic                  pass;
		logic                  complete;
		logic                  three;
		logic                  quad;
		logic                  frame_end;
	} spbi_entry_t;

	typedef enum logic {
		BK_GATHER,
		BK_DRAIN
	} spbi_back_state_t;

endpackage

// ===== rtl/core/spbi_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spbi_front
// Holds the registers and frame counters, takes input requests and tags
// each with its buffer slot, block end and frame end.
// ----------------------------------------------------------------------------
module spbi_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_write_en,
	input  logic [spbi_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [spbi_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [spbi_pkg::DATA_WIDTH-1:0] data_in,
	output logic                           push,
	output spbi_pkg::spbi_entry_t          entry,
	input  logic                           q_full
);

	logic [spbi_pkg::BPS_W-1:0]   bps_q;
	logic [spbi_pkg::FRAME_W-1:0] fsym_q;
	logic [spbi_pkg::FILL_W-1:0]  fill_q;
	logic [spbi_pkg::FRAME_W-1:0] spos_q;
	logic                         fbd_q;

	logic [spbi_pkg::FRAME_W-1:0] slen;
	logic                         il;
	logic                         three;
	logic                         quad;
	logic [spbi_pkg::FILL_W-1:0]  blen;
	logic [spbi_pkg::FILL_W-1:0]  plen;
	logic [spbi_pkg::FILL_W-1:0]  fill_eff;
	logic [spbi_pkg::FILL_W-1:0]  fill_inc;
	logic [spbi_pkg::FRAME_W-1:0] spos_add;
	logic                         complete;
	logic                         frame_end;
	logic [spbi_pkg::FILL_W-1:0]  fill_d;
	logic [spbi_pkg::FRAME_W-1:0] spos_d;
	logic                         fbd_d;
	logic                         cfg_hit;

	assign in_stall = q_full;
	assign push     = in_valid && !q_full;
	assign cfg_hit  = cfg_write_en && (cfg_index == spbi_pkg::REG_BITS_PER_SYMBOL ||
	                  cfg_index == spbi_pkg::REG_FRAME_SYMBOLS);

	always_comb begin
		if (fsym_q == '0) begin
			slen = spbi_pkg::FRAME_W'(1);
		end else if (fsym_q > spbi_pkg::FRAME_W'(spbi_pkg::MAX_FRAME_SYMBOLS)) begin
			slen = spbi_pkg::FRAME_W'(spbi_pkg::MAX_FRAME_SYMBOLS);
		end else begin
			slen = fsym_q;
		end
		quad  = (bps_q == spbi_pkg::BPS_W'(4));
		il    = (quad || bps_q == spbi_pkg::BPS_W'(2)) && slen >= spbi_pkg::FRAME_W'(2);
		three = slen[0] && !fbd_q;
		unique case ({three, quad})
			2'b00:   blen = spbi_pkg::FILL_W'(4);
			2'b01:   blen = spbi_pkg::FILL_W'(8);
			2'b10:   blen = spbi_pkg::FILL_W'(6);
			default: blen = spbi_pkg::FILL_W'(12);
		endcase
		plen = (bps_q == '0) ? spbi_pkg::FILL_W'(1) : spbi_pkg::FILL_W'(bps_q);

		fill_d    = fill_q;
		spos_d    = spos_q;
		fbd_d     = fbd_q;
		complete  = 1'b0;
		frame_end = 1'b0;
		fill_eff  = fill_q;
		fill_inc  = fill_q + spbi_pkg::FILL_W'(1);
		spos_add  = spos_q + spbi_pkg::FRAME_W'(1);

		if (!il) begin
			fill_d = fill_inc;
			if (fill_inc >= plen) begin
				fill_d = '0;
				spos_d = spos_add;
				if (spos_add >= slen) begin
					frame_end = 1'b1;
					spos_d    = '0;
					fbd_d     = 1'b0;
				end
			end
		end else begin
			if (fill_q >= blen) begin
				fill_eff = '0;
			end
			fill_inc = fill_eff + spbi_pkg::FILL_W'(1);
			spos_add = spos_q + (three ? spbi_pkg::FRAME_W'(3) : spbi_pkg::FRAME_W'(2));
			fill_d   = fill_inc;
			if (fill_inc >= blen) begin
				complete  = 1'b1;
				fill_d    = '0;
				spos_d    = spos_add;
				fbd_d     = fbd_q || three;
				if (spos_add >= slen) begin
					frame_end = 1'b1;
					spos_d    = '0;
					fbd_d     = 1'b0;
				end
			end
		end

		entry.data      = data_in;
		entry.widx      = spbi_pkg::BUF_IDX_W'(fill_eff);
		entry.pass      = !il;
		entry.complete  = complete;
		entry.three     = three;
		entry.quad      = quad;
		entry.frame_end = frame_end;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bps_q  <= spbi_pkg::BPS_RESET;
			fsym_q <= spbi_pkg::FRAME_RESET;
			fill_q <= '0;
			spos_q <= '0;
			fbd_q  <= 1'b0;
		end else if (cfg_hit) begin
			if (cfg_index == spbi_pkg::REG_BITS_PER_SYMBOL) begin
				bps_q <= cfg_data[spbi_pkg::BPS_W-1:0];
			end else begin
				fsym_q <= cfg_data[spbi_pkg::FRAME_W-1:0];
			end
			fill_q <= '0;
			spos_q <= '0;
			fbd_q  <= 1'b0;
		end else if (push) begin
			fill_q <= fill_d;
			spos_q <= spos_d;
			fbd_q  <= fbd_d;
		end
	end

endmodule

// ===== rtl/core/spbi_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spbi_queue
// Short request queue between the front and the back.
// ----------------------------------------------------------------------------
module spbi_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  spbi_pkg::spbi_entry_t push_entry,
	output logic                  full,
	input  logic                  pop,
	output logic                  valid,
	output spbi_pkg::spbi_entry_t head
);

	localparam int PTR_W = (spbi_pkg::QUEUE_DEPTH > 1) ? $clog2(spbi_pkg::QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(spbi_pkg::QUEUE_DEPTH + 1);

	spbi_pkg::spbi_entry_t slot_q [spbi_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0]      wptr_q;
	logic [PTR_W-1:0]      rptr_q;
	logic [CNT_W-1:0]      count_q;

	assign full  = (count_q == CNT_W'(spbi_pkg::QUEUE_DEPTH));
	assign valid = (count_q != '0);
	assign head  = slot_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == PTR_W'(spbi_pkg::QUEUE_DEPTH - 1)) ? '0 :
				          wptr_q + PTR_W'(1);
			end
			if (pop) begin
				rptr_q <= (rptr_q == PTR_W'(spbi_pkg::QUEUE_DEPTH - 1)) ? '0 :
				          rptr_q + PTR_W'(1);
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + CNT_W'(1);
				2'b01:   count_q <= count_q - CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== rtl/core/spbi_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spbi_back
// Gathers block items into the buffer, drains each completed block in
// interleaved order and drives the output register.
// ----------------------------------------------------------------------------
module spbi_back (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            q_valid,
	input  spbi_pkg::spbi_entry_t           q_head,
	output logic                            q_pop,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [spbi_pkg::DATA_WIDTH-1:0] data_out,
	output logic                            last_of_burst,
	output logic                            last_of_frame
);

	spbi_pkg::spbi_back_state_t state_q, state_d;

	logic [spbi_pkg::DATA_WIDTH-1:0] buffer_q [spbi_pkg::BUF_DEPTH];
	logic                            three_q;
	logic                            quad_q;
	logic                            end_q;
	logic [1:0]                      row_q;
	logic [1:0]                      col_q;
	logic                            out_valid_q;
	logic [spbi_pkg::DATA_WIDTH-1:0] data_q;
	logic                            burst_q;
	logic                            frame_q;

	logic                            load_ok;
	logic                            load;
	logic                            wr_en;
	logic                            job_ld;
	logic                            adv;
	logic                            last;
	logic [1:0]                      row_max;
	logic [1:0]                      col_max;
	logic [spbi_pkg::BUF_IDX_W-1:0]  rd_idx;
	logic                            ld_burst;
	logic                            ld_frame;

	assign out_valid     = out_valid_q;
	assign data_out      = data_q;
	assign last_of_burst = burst_q;
	assign last_of_frame = frame_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= spbi_pkg::BK_GATHER;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		load_ok  = !out_valid_q || !out_stall;
		row_max  = three_q ? 2'd2 : 2'd1;
		col_max  = quad_q ? 2'd3 : 2'd1;
		last     = (row_q == row_max) && (col_q == col_max);
		rd_idx   = (spbi_pkg::BUF_IDX_W'(row_q) << (quad_q ? 2 : 1)) +
		           spbi_pkg::BUF_IDX_W'(col_q);
		state_d  = state_q;
		q_pop    = 1'b0;
		wr_en    = 1'b0;
		job_ld   = 1'b0;
		load     = 1'b0;
		adv      = 1'b0;
		ld_burst = 1'b1;
		ld_frame = q_head.frame_end;
		unique case (state_q)
			spbi_pkg::BK_GATHER: begin
				if (q_valid) begin
					if (q_head.pass) begin
						if (load_ok) begin
							q_pop = 1'b1;
							load  = 1'b1;
						end
					end else begin
						q_pop = 1'b1;
						wr_en = 1'b1;
						if (q_head.complete) begin
							job_ld  = 1'b1;
							state_d = spbi_pkg::BK_DRAIN;
						end
					end
				end
			end
			spbi_pkg::BK_DRAIN: begin
				if (load_ok) begin
					load     = 1'b1;
					adv      = 1'b1;
					ld_burst = last;
					ld_frame = last && end_q;
					if (last) begin
						state_d = spbi_pkg::BK_GATHER;
					end
				end
			end
			default: state_d = spbi_pkg::BK_GATHER;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			buffer_q[q_head.widx] <= q_head.data;
		end
		if (job_ld) begin
			three_q <= q_head.three;
			quad_q  <= q_head.quad;
			end_q   <= q_head.frame_end;
			row_q   <= '0;
			col_q   <= '0;
		end else if (adv) begin
			if (row_q == row_max) begin
				row_q <= '0;
				col_q <= col_q + 2'd1;
			end else begin
				row_q <= row_q + 2'd1;
			end
		end
		if (load) begin
			if (state_q == spbi_pkg::BK_DRAIN) begin
				data_q <= buffer_q[rd_idx];
			end else begin
				data_q <= q_head.data;
			end
			burst_q <= ld_burst;
			frame_q <= ld_frame;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	a_drain_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == spbi_pkg::BK_DRAIN) |-> (rd_idx < spbi_pkg::BUF_IDX_W'(spbi_pkg::BUF_DEPTH)))
		else $error("drain index beyond buffer");

	a_no_pop_in_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == spbi_pkg::BK_DRAIN) |-> !q_pop)
		else $error("queue popped while draining");

	a_frame_ends_burst: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && frame_q) |-> burst_q)
		else $error("frame end without burst end");

	a_last_leaves_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == spbi_pkg::BK_DRAIN && load && last) |=> (state_q == spbi_pkg::BK_GATHER))
		else $error("drain did not finish on last item");

endmodule

// ===== rtl/core/symbol_pair_bit_interleaver.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// symbol_pair_bit_interleaver
// Interleaves the items of symbol pairs (or of a leading symbol triple in
// odd frames); other symbol sizes and one-symbol frames pass through.
// ----------------------------------------------------------------------------
//  channel  signals                              direction
//  cfg      cfg_write_en cfg_index cfg_data      in
//  in       in_valid in_stall data_in            in (in_stall out)
//  out      out_valid out_stall data_out
//           last_of_burst last_of_frame          out (out_stall in)
//
//  Pass-through sizes: one item per cycle while out_stall allows, one result per request.
//  Interleaving: a block of L items (4, 6, 8 or 12) is gathered into the single
//  block buffer and then drained from it in interleaved order; the back end takes
//  no new items from the queue while it drains.
//  Reset needs no clearing pass; the buffer is always written before read.
//  out_stall holds the output register; the queue then fills and raises in_stall.
// ----------------------------------------------------------------------------
module symbol_pair_bit_interleaver (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_write_en,
	input  logic [spbi_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [spbi_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [spbi_pkg::DATA_WIDTH-1:0] data_in,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [spbi_pkg::DATA_WIDTH-1:0] data_out,
	output logic                            last_of_burst,
	output logic                            last_of_frame
);

	logic                  push;
	logic                  q_full;
	logic                  q_valid;
	logic                  q_pop;
	spbi_pkg::spbi_entry_t push_entry;
	spbi_pkg::spbi_entry_t q_head;

	spbi_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write_en (cfg_write_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.data_in      (data_in),
		.push         (push),
		.entry        (push_entry),
		.q_full       (q_full)
	);

	spbi_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (q_full),
		.pop        (q_pop),
		.valid      (q_valid),
		.head       (q_head)
	);

	spbi_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_valid       (q_valid),
		.q_head        (q_head),
		.q_pop         (q_pop),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.data_out      (data_out),
		.last_of_burst (last_of_burst),
		.last_of_frame (last_of_frame)
	);

endmodule

// ===== verif/spbi_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spbi_checker
// Watches the register port and both streaming channels of the symbol pair
// bit interleaver, keeps its own copy of the interleaver state, works out the
// reordered items that each accepted request must produce and compares every
// accepted result field by field against the oldest one still owed.
// ----------------------------------------------------------------------------
module spbi_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_write_en,
	input  logic [spbi_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [spbi_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            in_valid,
	input  logic                            in_stall,
	input  logic [spbi_pkg::DATA_WIDTH-1:0] data_in,
	input  logic                            out_valid,
	input  logic                            out_stall,
	input  logic [spbi_pkg::DATA_WIDTH-1:0] data_out,
	input  logic                            last_of_burst,
	input  logic                            last_of_frame,
	output int                              mismatches,
	output int                              owed,
	output int                              compared
);
	import spbi_pkg::*;

	typedef struct packed {
		logic [DATA_WIDTH-1:0] data;
		logic                  burst_end;
		logic                  frame_end;
	} reordered_item_t;

	reordered_item_t       owed_items[$];

	logic [BPS_W-1:0]      bps;
	logic [FRAME_W-1:0]    frame_syms;
	logic [DATA_WIDTH-1:0] gathered[BUF_DEPTH];
	int                    fill;
	int                    sym_pos;
	logic                  triple_done;

	task automatic report_mismatch(input string what, input int got, input int want);
		if (mismatches < 50)
			$display("%t mismatch on result %0d: %s got %0h want %0h",
				$time, compared, what, got, want);
		mismatches++;
	endtask

	task automatic restart_frame();
		fill = 0;
		sym_pos = 0;
		triple_done = 1'b0;
	endtask

	task automatic owe(input logic [DATA_WIDTH-1:0] d, input logic be, input logic fe);
		reordered_item_t r;
		r.data = d;
		r.burst_end = be;
		r.frame_end = fe;
		owed_items.push_back(r);
	endtask

	task automatic predict_request(input logic [DATA_WIDTH-1:0] d);
		int   f;
		int   s;
		int   len;
		int   groups;
		int   blen;
		int   n;
		logic ends;
		logic triple;
		f = bps;
		s = frame_syms;
		if (s == 0)
			s = 1;
		if (s > MAX_FRAME_SYMBOLS)
			s = MAX_FRAME_SYMBOLS;
		ends = 1'b0;
		if (!((f == 2 || f == 4) && s >= 2)) begin
			len = (f == 0) ? 1 : f;
			fill = (fill + 1) & 15;
			if (fill >= len) begin
				fill = 0;
				sym_pos++;
				if (sym_pos >= s) begin
					ends = 1'b1;
					sym_pos = 0;
					triple_done = 1'b0;
				end
			end
			owe(d, 1'b1, ends);
		end else begin
			triple = s[0] && !triple_done;
			groups = triple ? 3 : 2;
			blen = groups * f;
			if (fill >= blen)
				fill = 0;
			gathered[fill % BUF_DEPTH] = d;
			fill++;
			if (fill >= blen) begin
				sym_pos += groups;
				if (triple)
					triple_done = 1'b1;
				if (sym_pos >= s)
					ends = 1'b1;
				for (n = 0; n < blen; n++)
					owe(gathered[(f * (n % groups) + n / groups) % BUF_DEPTH],
						n == blen - 1, (n == blen - 1) && ends);
				fill = 0;
				if (ends) begin
					sym_pos = 0;
					triple_done = 1'b0;
				end
			end
		end
	endtask

	task automatic check_result();
		reordered_item_t r;
		if (owed_items.size() == 0) begin
			report_mismatch("unexpected result, data", data_out, 0);
		end else begin
			r = owed_items.pop_front();
			if (data_out !== r.data)
				report_mismatch("data_out", data_out, r.data);
			if (last_of_burst !== r.burst_end)
				report_mismatch("last_of_burst", last_of_burst, r.burst_end);
			if (last_of_frame !== r.frame_end)
				report_mismatch("last_of_frame", last_of_frame, r.frame_end);
		end
		compared++;
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			bps = BPS_RESET;
			frame_syms = FRAME_RESET;
			restart_frame();
			owed_items.delete();
			mismatches = 0;
			compared = 0;
		end else begin
			if (out_valid && !out_stall)
				check_result();
			if (cfg_write_en) begin
				if (cfg_index == REG_BITS_PER_SYMBOL) begin
					bps = cfg_data[BPS_W-1:0];
					restart_frame();
				end else if (cfg_index == REG_FRAME_SYMBOLS) begin
					frame_syms = cfg_data[FRAME_W-1:0];
					restart_frame();
				end
			end
			if (in_valid && !in_stall)
				predict_request(data_in);
		end
		owed = owed_items.size();
	end

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the symbol pair bit interleaver: a short directed
// run over pair, triple, one-symbol and zero-size frames, then random frames
// of random symbol sizes and lengths, including lengths at and beyond the
// saturation limit, under three idling regimes. A separate checker predicts
// and compares every result.
// ----------------------------------------------------------------------------
module tb_top;
	import spbi_pkg::*;

	localparam int RANDOM_ITEMS   = 360;
	localparam int SETTLE_CYCLES  = 24;
	localparam int WATCHDOG_LIMIT = 3000;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = CFG_IDX_W'(3);

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_write_en = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic [DATA_WIDTH-1:0] data_in = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic [DATA_WIDTH-1:0] data_out;
	logic                  last_of_burst;
	logic                  last_of_frame;

	int mismatches;
	int owed;
	int compared;
	int send_idle_pct = 30;
	int recv_idle_pct = 74;
	int requests = 0;
	int settings = 0;
	int quiet_cycles = 0;

	always #5 clk = ~clk;

	symbol_pair_bit_interleaver u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write_en (cfg_write_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.data_in      (data_in),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.data_out     (data_out),
		.last_of_burst(last_of_burst),
		.last_of_frame(last_of_frame)
	);

	spbi_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write_en (cfg_write_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.data_in      (data_in),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.data_out     (data_out),
		.last_of_burst(last_of_burst),
		.last_of_frame(last_of_frame),
		.mismatches   (mismatches),
		.owed         (owed),
		.compared     (compared)
	);

	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < recv_idle_pct);
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%t no request or result moved for %0d cycles", $time, quiet_cycles);
			$display("== FAIL ==");
			$finish;
		end
	end

	function automatic logic [DATA_WIDTH-1:0] random_item();
		if ($urandom_range(1))
			return DATA_WIDTH'($urandom_range(1));
		return DATA_WIDTH'($urandom_range(255));
	endfunction

	task automatic send_request(input logic [DATA_WIDTH-1:0] d);
		int gap;
		gap = 0;
		while (gap < 24 && $urandom_range(99) < send_idle_pct)
			gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		data_in <= d;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		requests++;
	endtask

	// drop valid and wait for every owed result; a partial block stays in the buffer
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (owed != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
		cfg_write_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= CFG_DATA_W'(value);
		@(posedge clk);
	endtask

	task automatic set_mode(input int f, input int s);
		int noise;
		noise = ($urandom_range(3) == 0) ? $urandom_range(1, 511) : 0;
		write_reg(REG_BITS_PER_SYMBOL, f | (noise << BPS_W));
		write_reg(REG_FRAME_SYMBOLS, s);
		if ($urandom_range(4) == 0)
			write_reg($urandom_range(1) ? REG_SPARE_A : REG_SPARE_B, $urandom_range(8191));
		cfg_write_en <= 1'b0;
		settings++;
	endtask

	initial begin
		int f;
		int s;
		int s_eff;
		int len;
		int n;
		int stage;
		int random_sent;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset setting: one pair frame of two-item symbols
		send_request(8'h00);
		send_request(8'hFF);
		send_request(8'hAA);
		send_request(8'h55);
		settle();
		// one-symbol frame passes through
		set_mode(2, 1);
		send_request(8'h01);
		send_request(8'h80);
		send_request(8'hFE);
		settle();
		// odd frame opens with a triple block
		set_mode(2, 3);
		repeat (6) send_request(random_item());
		settle();
		// zero size and zero length
		set_mode(0, 0);
		send_request(8'h7F);
		send_request(8'h00);
		settle();
		// partial block, dropped by the next write
		set_mode(4, 2);
		repeat (5) send_request(random_item());
		settle();

		random_sent = 0;
		while (random_sent < RANDOM_ITEMS) begin
			stage = random_sent * 3 / RANDOM_ITEMS;
			send_idle_pct = (stage == 0) ? 30 : (stage == 1) ? 74 : 0;
			recv_idle_pct = (stage == 0) ? 74 : (stage == 1) ? 30 : 0;
			if ($urandom_range(9) < 7)
				f = $urandom_range(1) ? 2 : 4;
			else
				f = $urandom_range(15);
			if ($urandom_range(4) != 0)
				s = $urandom_range(1, 9);
			else
				case ($urandom_range(4))
					0: s = 0;
					1: s = MAX_FRAME_SYMBOLS - 1;
					2: s = MAX_FRAME_SYMBOLS;
					3: s = MAX_FRAME_SYMBOLS + 1;
					default: s = 8191;
				endcase
			set_mode(f, s);
			s_eff = (s == 0) ? 1 : (s > MAX_FRAME_SYMBOLS) ? MAX_FRAME_SYMBOLS : s;
			len = (f == 0) ? 1 : f;
			if (s_eff > 9) begin
				n = $urandom_range(8, 40);
			end else begin
				n = s_eff * len * $urandom_range(1, 3);
				if (n > 48)
					n = s_eff * len;
				if ($urandom_range(3) == 0)
					n += $urandom_range(1, 2 * len);
			end
			repeat (n) send_request(random_item());
			random_sent += n;
			settle();
		end

		$display("Sent %0d requests under %0d register settings, %0d results compared.",
			requests, settings, compared);
		$display("Covered pair and triple blocks, pass-through sizes, one-symbol and zero frames,");
		$display("and frame lengths at and beyond the saturation limit.");
		if (mismatches == 0 && owed == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
